// ===== src/base32_stream_encoder_assert.svh =====
// assertion macros for the base32 stream encoder
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef BASE32_STREAM_ENCODER_ASSERT_SVH
`define BASE32_STREAM_ENCODER_ASSERT_SVH

// condition holds at every edge out of reset
`define B32E_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("base32 encoder check failed");

// antecedent implies consequent in the same cycle
`define B32E_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("base32 encoder check failed");

// antecedent implies consequent in the next cycle
`define B32E_IMPLIES_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("base32 encoder check failed");

`endif

// ===== src/b32e_pkg.sv =====
// shared types, constants and the symbol alphabet of the base32 encoder
// no dependencies
package b32e_pkg;

    localparam int unsigned SYM_BITS  = 5;
    localparam int unsigned POOL_BITS = 4;
    localparam int unsigned MAX_SYMS  = 3;

    localparam logic [0:31][7:0] ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    typedef logic [SYM_BITS-1:0] t_sym;

    // symbols made by one input beat, first one in slot 0
    typedef struct packed {
        t_sym [MAX_SYMS-1:0] sym;
        logic [1:0]          cnt;
        logic                last;
    } t_burst;

    // serializer status seen by the top level
    typedef struct packed {
        logic [1:0] left;
        logic       load;
    } t_status;

    function automatic logic [7:0] sym_to_char(input t_sym s);
        return ALPHABET[s];
    endfunction

endpackage

// ===== src/base32_stream_encoder.sv =====
// base32 stream encoder top level: one byte in, one to three characters out
// path: a taken byte's symbols go to the symbol hold, then each character is loaded into the output register
// throughput: one character per cycle while i_stall is low, set by the single output register;
// a byte makes one to three characters (1.6 on average), and the next byte is taken as its last one loads
// reset: synchronous active low, empties the bit pool, symbol hold and output register
// depends on b32e_pkg, b32e_split, b32e_serial and base32_stream_encoder_assert.svh
`include "base32_stream_encoder_assert.svh"

module base32_stream_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_out_last
);
    import b32e_pkg::*;

    t_burst  burst;
    t_status status;
    logic    ready;
    logic    take;

    assign take    = i_valid && ready;
    assign o_stall = !ready;

    b32e_split u_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_burst   (burst)
    );

    b32e_serial u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_burst    (burst),
        .o_ready    (ready),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last),
        .o_status   (status)
    );

    // every beat yields at least one character
    `B32E_IMPLIES_NEXT(a_beat_has_char, take, status.left != 2'd0)
    // empty hold never blocks the input
    `B32E_IMPLIES(a_empty_ready, status.left == 2'd0, !o_stall)
    // only alphabet characters leave the block
    `B32E_IMPLIES(a_char_legal, o_valid,
        (o_out_char >= 8'h41 && o_out_char <= 8'h5A) ||
        (o_out_char >= 8'h32 && o_out_char <= 8'h37))
    // a loaded character shows up as valid next cycle
    `B32E_IMPLIES_NEXT(a_load_shows, status.load, o_valid)

endmodule

// ===== src/b32e_split.sv =====
// bit pool and symbol slicing for one input beat
// depends on b32e_pkg
module b32e_split (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_in_byte,
    input  logic            i_in_last,
    output b32e_pkg::t_burst o_burst
);
    import b32e_pkg::*;

    logic [POOL_BITS-1:0] r_bits;
    logic [2:0]           r_cnt;
    logic [POOL_BITS-1:0] n_bits;
    logic [2:0]           n_cnt;

    logic [11:0] pool;
    logic [3:0]  c;
    logic        two;
    logic [2:0]  sh0;
    logic [2:0]  sh1;
    logic [2:0]  rem;
    logic        flush;
    t_sym        sym0;
    t_sym        sym1;
    t_sym        sym2;
    logic [POOL_BITS-1:0] mask;

    always_comb begin
        pool  = {r_bits, i_in_byte};
        c     = {1'b0, r_cnt} + 4'd8;
        two   = (c >= 4'd10);
        sh0   = 3'(c - 4'd5);
        sh1   = 3'(c - 4'd10);
        rem   = two ? sh1 : sh0;
        flush = i_in_last && (rem != 3'd0);
        sym0  = t_sym'(pool >> sh0);
        sym1  = t_sym'(pool >> sh1);
        sym2  = t_sym'({pool, 5'b0} >> rem);
        mask  = POOL_BITS'((5'd1 << rem) - 5'd1);

        o_burst.sym[0] = sym0;
        o_burst.sym[1] = two ? sym1 : sym2;
        o_burst.sym[2] = sym2;
        o_burst.cnt    = 2'd1 + {1'b0, two} + {1'b0, flush};
        o_burst.last   = i_in_last;

        n_bits = i_in_last ? '0 : (pool[POOL_BITS-1:0] & mask);
        n_cnt  = i_in_last ? 3'd0 : rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_cnt  <= 3'd0;
        end else if (i_take) begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== src/b32e_serial.sv =====
// holds one beat's symbols and sends them one per cycle, unless stalled, through the output register
// depends on b32e_pkg
module b32e_serial (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  b32e_pkg::t_burst i_burst,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_char,
    output logic             o_out_last,
    output b32e_pkg::t_status o_status
);
    import b32e_pkg::*;

    t_sym [MAX_SYMS-1:0] r_sym;
    logic [1:0]          r_left;
    logic [1:0]          r_pos;
    logic                r_last;
    logic                r_out_valid;
    logic [7:0]          r_out_char;
    logic                r_out_last;

    logic load;
    logic take;
    t_sym cur;

    always_comb begin
        load    = (r_left != 2'd0) && (!r_out_valid || !i_stall);
        o_ready = (r_left == 2'd0) || ((r_left == 2'd1) && load);
        take    = i_valid && o_ready;
        case (r_pos)
            2'd0:    cur = r_sym[0];
            2'd1:    cur = r_sym[1];
            2'd2:    cur = r_sym[2];
            default: cur = r_sym[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= 2'd0;
            r_pos       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_left <= i_burst.cnt;
                r_pos  <= 2'd0;
            end else if (load) begin
                r_left <= r_left - 2'd1;
                r_pos  <= r_pos + 2'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sym  <= i_burst.sym;
            r_last <= i_burst.last;
        end
        if (load) begin
            r_out_char <= sym_to_char(cur);
            r_out_last <= r_last && (r_left == 2'd1);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_out_last      = r_out_last;
    assign o_status.left   = r_left;
    assign o_status.load   = load;

endmodule
